// ===== hdl/gcb_pkg.sv =====
package gcb_pkg;

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_PAINT = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // font size codes
    localparam logic [1:0] FONT_12  = 2'd0;
    localparam logic [1:0] FONT_16  = 2'd1;
    localparam logic [1:0] FONT_24  = 2'd2;
    localparam logic [1:0] FONT_BAD = 2'd3;

    // saturation point of the cursor column
    localparam logic [7:0] COL_MAX = 8'hFF;

    // memory operation codes from controller to datapath
    localparam logic [2:0] MEM_NONE   = 3'd0;
    localparam logic [2:0] MEM_RD_A   = 3'd1;
    localparam logic [2:0] MEM_WR_A   = 3'd2;
    localparam logic [2:0] MEM_RD_B   = 3'd3;
    localparam logic [2:0] MEM_WR_B   = 3'd4;
    localparam logic [2:0] MEM_RD_REQ = 3'd5;
    localparam logic [2:0] MEM_CLR    = 3'd6;

    typedef struct packed {
        logic [1:0] req_type;
        logic       start_char;
        logic [6:0] pos_x;
        logic [5:0] pos_y;
        logic [7:0] glyph_byte;
        logic [1:0] font_size;
        logic       invert;
        logic [9:0] read_addr;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       font_error;
    } out_item_t;

    typedef struct packed {
        logic       capture;
        logic       prep;
        logic [2:0] mem_op;
        logic       clr_fill;
        logic       rd_capture;
        logic       load_result;
    } cmd_t;

    typedef struct packed {
        logic [1:0] new_req;
        logic       new_font_bad;
        logic       mask_a_any;
        logic       mask_b_any;
        logic       clr_last;
        logic       out_free;
    } status_t;

    // glyph height in rows, zero for the unsupported code
    function automatic logic [4:0] font_height(input logic [1:0] fs);
        logic [4:0] h;
        begin
            case (fs)
                FONT_12: h = 5'd12;
                FONT_16: h = 5'd16;
                FONT_24: h = 5'd24;
                default: h = 5'd0;
            endcase
            return h;
        end
    endfunction

endpackage

// ===== hdl/gcb_ctrl.sv =====
module gcb_ctrl
    import gcb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_CLEAR = 4'd2;
    localparam logic [3:0] S_PREP  = 4'd3;
    localparam logic [3:0] S_RDA   = 4'd4;
    localparam logic [3:0] S_WRA   = 4'd5;
    localparam logic [3:0] S_RDB   = 4'd6;
    localparam logic [3:0] S_WRB   = 4'd7;
    localparam logic [3:0] S_RREAD = 4'd8;
    localparam logic [3:0] S_RWAIT = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.mem_op      = MEM_NONE;
        cmd.capture     = in_valid && in_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (st.new_req)
                        REQ_CLEAR: state_next = S_CLEAR;
                        REQ_PAINT: state_next = st.new_font_bad ? S_DONE : S_PREP;
                        REQ_READ:  state_next = S_RREAD;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_INIT:
            begin
                cmd.mem_op = MEM_CLR;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                cmd.mem_op   = MEM_CLR;
                cmd.clr_fill = 1'b1;
                if (st.clr_last)
                    state_next = S_DONE;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_RDA;
            end
            S_RDA:
            begin
                // masks are settled now; skip untouched page bytes
                if (st.mask_a_any)
                begin
                    cmd.mem_op = MEM_RD_A;
                    state_next = S_WRA;
                end
                else if (st.mask_b_any)
                begin
                    state_next = S_RDB;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WRA:
            begin
                cmd.mem_op = MEM_WR_A;
                state_next = st.mask_b_any ? S_RDB : S_DONE;
            end
            S_RDB:
            begin
                cmd.mem_op = MEM_RD_B;
                state_next = S_WRB;
            end
            S_WRB:
            begin
                cmd.mem_op = MEM_WR_B;
                state_next = S_DONE;
            end
            S_RREAD:
            begin
                cmd.mem_op = MEM_RD_REQ;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register, clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    // a result is never loaded over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> st.out_free)
        else $error("result loaded while output register busy");

    // an unsupported font paint goes straight to the result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture && st.new_req == REQ_PAINT && st.new_font_bad |=> state_reg == S_DONE)
        else $error("bad font transaction touched the buffer");

    // a fill pass ends after its last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR || state_reg == S_INIT) && st.clr_last
        |=> state_reg != S_CLEAR && state_reg != S_INIT)
        else $error("fill pass overran the buffer");

endmodule

// ===== hdl/gcb_datapath.sv =====
module gcb_datapath
    import gcb_pkg::*;
#(
    parameter int DISPLAY_WIDTH = 128,
    parameter int DISPLAY_PAGES = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    output out_item_t out_item,
    output logic      out_valid,
    input  logic      out_ready,
    input  cmd_t      cmd,
    output status_t   st
);

    localparam int STORE_BYTES = DISPLAY_WIDTH * DISPLAY_PAGES;
    localparam int ROW_LIMIT   = DISPLAY_PAGES * 8;
    localparam int AW          = $clog2(STORE_BYTES);

    in_item_t        req_reg;
    logic [7:0]      cur_col_reg;
    logic [6:0]      cur_row_reg;
    logic [6:0]      cur_top_reg;
    logic [7:0]      mask_a_reg;
    logic [7:0]      val_a_reg;
    logic [7:0]      mask_b_reg;
    logic [7:0]      val_b_reg;
    logic [AW-1:0]   addr_a_reg;
    logic [AW-1:0]   addr_b_reg;
    logic [AW-1:0]   clr_cnt_reg;
    logic [7:0]      rd_byte_reg;
    out_item_t       out_item_reg;
    logic            out_valid_reg;

    logic [7:0]      frame_mem [STORE_BYTES];
    logic [7:0]      mem_q;
    logic [AW-1:0]   mem_addr;
    logic            mem_we;
    logic [7:0]      mem_wdata;

    logic [7:0]      col0;
    logic [6:0]      row0;
    logic [6:0]      top0;
    logic [4:0]      height;
    logic [6:0]      row_off;
    logic [7:0]      stop;
    logic [7:0]      live;
    logic [3:0]      page_a;
    logic [3:0]      page_b;
    logic            col_on;
    logic [7:0]      mask_a_next;
    logic [7:0]      val_a_next;
    logic [7:0]      mask_b_next;
    logic [7:0]      val_b_next;
    logic [7:0]      col_next;
    logic [6:0]      row_next;
    logic            clr_last;
    logic            read_in_range;

    // paint setup: which pixels of the column land in which page byte
    always_comb
    begin
        logic [6:0] step;
        logic [6:0] row_j;
        logic       pix;
        col0    = req_reg.start_char ? {1'b0, req_reg.pos_x} : cur_col_reg;
        row0    = req_reg.start_char ? {1'b0, req_reg.pos_y} : cur_row_reg;
        top0    = req_reg.start_char ? {1'b0, req_reg.pos_y} : cur_top_reg;
        height  = font_height(req_reg.font_size);
        row_off = row0 - top0;
        page_a  = row0[6:3];
        page_b  = page_a + 4'd1;
        col_on  = (32'(col0) < DISPLAY_WIDTH);
        for (int j = 0; j < 8; j++)
        begin
            step    = row_off + 7'(j + 1);
            stop[j] = (step >= {2'b00, height});
        end
        live[0] = 1'b1;
        for (int j = 1; j < 8; j++)
            live[j] = live[j-1] & ~stop[j-1];
        mask_a_next = '0;
        val_a_next  = '0;
        mask_b_next = '0;
        val_b_next  = '0;
        for (int j = 0; j < 8; j++)
        begin
            row_j = row0 + 7'(j);
            pix   = req_reg.glyph_byte[3'(7 - j)] ^ req_reg.invert;
            if (live[j] && col_on && (32'(row_j) < ROW_LIMIT))
            begin
                if (row_j[6:3] == page_a)
                begin
                    mask_a_next[row_j[2:0]] = 1'b1;
                    val_a_next[row_j[2:0]]  = pix;
                end
                else
                begin
                    mask_b_next[row_j[2:0]] = 1'b1;
                    val_b_next[row_j[2:0]]  = pix;
                end
            end
        end
        // cursor after this byte
        if (|stop)
        begin
            row_next = top0;
            col_next = (col0 == COL_MAX) ? COL_MAX : col0 + 8'd1;
        end
        else
        begin
            row_next = row0 + 7'd8;
            col_next = col0;
        end
    end

    // request capture and paint registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= in_item;
        if (cmd.prep)
        begin
            val_a_reg  <= val_a_next;
            val_b_reg  <= val_b_next;
            addr_a_reg <= AW'(32'(col0) * DISPLAY_PAGES + 32'(page_a));
            addr_b_reg <= AW'(32'(col0) * DISPLAY_PAGES + 32'(page_b));
        end
        if (cmd.rd_capture)
            rd_byte_reg <= read_in_range ? mem_q : 8'h00;
        if (cmd.load_result)
            out_item_reg <= '{
                read_data:  (req_reg.req_type == REQ_READ) ? rd_byte_reg : 8'h00,
                font_error: (req_reg.req_type == REQ_PAINT) &&
                            (req_reg.font_size == FONT_BAD)
            };
    end

    // cursor, masks, fill counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            cur_top_reg   <= '0;
            mask_a_reg    <= '0;
            mask_b_reg    <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.prep)
            begin
                cur_col_reg <= col_next;
                cur_row_reg <= row_next;
                cur_top_reg <= top0;
                mask_a_reg  <= mask_a_next;
                mask_b_reg  <= mask_b_next;
            end
            if (cmd.mem_op == MEM_CLR)
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + 1'b1;
            if (cmd.load_result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign clr_last      = (clr_cnt_reg == AW'(STORE_BYTES - 1));
    assign read_in_range = (32'(req_reg.read_addr) < STORE_BYTES);

    // single port access: address, enable and merged write byte
    always_comb
    begin
        mem_addr  = addr_a_reg;
        mem_we    = 1'b0;
        mem_wdata = (mem_q & ~mask_a_reg) | (val_a_reg & mask_a_reg);
        case (cmd.mem_op)
            MEM_RD_A:
            begin
                mem_addr = addr_a_reg;
            end
            MEM_WR_A:
            begin
                mem_addr = addr_a_reg;
                mem_we   = |mask_a_reg;
            end
            MEM_RD_B:
            begin
                mem_addr = addr_b_reg;
            end
            MEM_WR_B:
            begin
                mem_addr  = addr_b_reg;
                mem_we    = |mask_b_reg;
                mem_wdata = (mem_q & ~mask_b_reg) | (val_b_reg & mask_b_reg);
            end
            MEM_RD_REQ:
            begin
                mem_addr = AW'(req_reg.read_addr);
            end
            MEM_CLR:
            begin
                mem_addr  = clr_cnt_reg;
                mem_we    = 1'b1;
                mem_wdata = {8{cmd.clr_fill & req_reg.invert}};
            end
            default:
            begin
                mem_addr = addr_a_reg;
            end
        endcase
    end

    // frame buffer
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_addr] <= mem_wdata;
        mem_q <= frame_mem[mem_addr];
    end

    assign out_item = out_item_reg;
    assign out_valid = out_valid_reg;

    assign st.new_req      = in_item.req_type;
    assign st.new_font_bad = (in_item.font_size == FONT_BAD);
    assign st.mask_a_any   = |mask_a_reg;
    assign st.mask_b_any   = |mask_b_reg;
    assign st.clr_last     = clr_last;
    assign st.out_free     = !out_valid_reg || out_ready;

    // the two page bytes of one glyph byte never share a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (mask_a_reg & mask_b_reg) == 8'h00)
        else $error("overlapping page masks");

    // writes stay inside the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(mem_addr) < STORE_BYTES))
        else $error("frame buffer write out of range");

endmodule

// ===== hdl/glyph_column_blitter_core.sv =====
// Glyph column blitter: paints font bitmap bytes, most significant bit first, down the
// columns of a page-organised 1-bit frame buffer of DISPLAY_WIDTH x DISPLAY_PAGES bytes,
// clears the buffer to 0x00 or 0xFF and reads single bytes back; every transaction gives
// exactly one result. The buffer is a single-port memory, so timing follows its accesses:
// a paint byte reads and writes back each of the one or two page bytes that it touches
// and skips the buffer when all its pixels fall off-screen; a paint with an unsupported
// font size and the unused request code go straight to the result, a read makes one
// buffer access and a clear writes every byte. After reset the block zeroes the buffer,
// with in_ready low. A finished result waits in an output register, so the next
// transaction is taken while it is still pending.
module glyph_column_blitter_core
    import gcb_pkg::*;
#(
    parameter int DISPLAY_WIDTH = 128,
    parameter int DISPLAY_PAGES = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    cmd_t    cmd;
    status_t st;

    // sequencing of buffer accesses
    gcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // cursor, pixel masks, frame buffer and result register
    gcb_datapath #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .DISPLAY_PAGES (DISPLAY_PAGES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ===== tb/sv/glyph_column_blitter_core_tb.sv =====
module glyph_column_blitter_core_tb;
    import gcb_pkg::*;

    localparam int DISP_W     = 128;
    localparam int DISP_PAGES = 8;
    localparam int STORE      = DISP_W * DISP_PAGES;
    localparam int ROWS       = DISP_PAGES * 8;
    localparam int RANDOM_N   = 900;

    // request code that the block treats as no operation
    localparam logic [1:0] REQ_NOP = 2'd3;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    glyph_column_blitter_core #(
        .DISPLAY_WIDTH (DISP_W),
        .DISPLAY_PAGES (DISP_PAGES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // requests waiting to be offered, results waiting to arrive
    in_item_t  glyph_requests[$];
    out_item_t blit_outcomes[$];

    // shadow of the frame buffer and the pen position
    logic [7:0] frame_bytes [0:STORE-1];
    logic [7:0] pen_col;
    logic [6:0] pen_row;
    logic [6:0] col_top;

    bit failed        = 1'b0;
    int send_gap      = 0;
    bit send_burst    = 1'b0;
    int recv_gap      = 0;
    bit recv_burst    = 1'b0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int results_seen  = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short gaps, a few long ones, none at all during a burst
    function automatic int gap_len(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        else
            return $urandom_range(15, 40);
    endfunction

    // applies one request to the shadow state and returns its result
    function automatic out_item_t predict_blit(input in_item_t t);
        out_item_t  r;
        logic [4:0] h;
        logic [7:0] d;
        logic [6:0] depth;
        logic       ink;
        int         idx;
        r = '0;
        case (t.req_type)
            REQ_CLEAR:
            begin
                for (int i = 0; i < STORE; i++)
                    frame_bytes[i] = t.invert ? 8'hFF : 8'h00;
            end
            REQ_PAINT:
            begin
                case (t.font_size)
                    FONT_12: h = 5'd12;
                    FONT_16: h = 5'd16;
                    FONT_24: h = 5'd24;
                    default: h = 5'd0;
                endcase
                if (h == 5'd0)
                    r.font_error = 1'b1;
                else
                begin
                    if (t.start_char)
                    begin
                        pen_col = {1'b0, t.pos_x};
                        pen_row = {1'b0, t.pos_y};
                        col_top = {1'b0, t.pos_y};
                    end
                    d = t.glyph_byte;
                    for (int j = 0; j < 8; j++)
                    begin
                        ink = d[7] ^ t.invert;
                        // pixels off the panel are dropped but the pen still moves
                        if (pen_col < DISP_W && pen_row < ROWS)
                        begin
                            idx = pen_col * DISP_PAGES + (pen_row >> 3);
                            frame_bytes[idx][pen_row[2:0]] = ink;
                        end
                        d = d << 1;
                        pen_row = pen_row + 7'd1;
                        depth = pen_row - col_top;
                        if (depth >= h)
                        begin
                            pen_row = col_top;
                            if (pen_col != COL_MAX)
                                pen_col = pen_col + 8'd1;
                            break;
                        end
                    end
                end
            end
            REQ_READ:
            begin
                if (t.read_addr < STORE)
                    r.read_data = frame_bytes[t.read_addr];
            end
            default: ;
        endcase
        return r;
    endfunction

    // every field random, so unused bits toggle too
    function automatic in_item_t noise_fields();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    task automatic add_paint(input int start, input int x, input int y,
                             input logic [7:0] gb, input logic [1:0] fs, input bit inv);
        in_item_t t;
        t = noise_fields();
        t.req_type   = REQ_PAINT;
        t.start_char = 1'(start);
        t.pos_x      = 7'(x);
        t.pos_y      = 6'(y);
        t.glyph_byte = gb;
        t.font_size  = fs;
        t.invert     = inv;
        glyph_requests.push_back(t);
    endtask

    task automatic add_read(input int addr);
        in_item_t t;
        t = noise_fields();
        t.req_type  = REQ_READ;
        t.read_addr = 10'(addr);
        glyph_requests.push_back(t);
    endtask

    task automatic add_clear(input bit inv);
        in_item_t t;
        t = noise_fields();
        t.req_type = REQ_CLEAR;
        t.invert   = inv;
        glyph_requests.push_back(t);
    endtask

    // driver: offers queued requests, predicts each accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                blit_outcomes.push_back(predict_blit(in_item));
            if ($urandom_range(0, 63) == 0)
                send_burst = !send_burst;
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (glyph_requests.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_item  <= glyph_requests.pop_front();
                    send_gap = gap_len(send_burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks results in order and paces out_ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (blit_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result read_data %02h font_error %0d",
                             $time, out_item.read_data, out_item.font_error);
                    failed = 1'b1;
                end
                else
                begin
                    out_item_t want;
                    want = blit_outcomes.pop_front();
                    if (out_item.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %02h got %02h",
                                 $time, want.read_data, out_item.read_data);
                        failed = 1'b1;
                    end
                    if (out_item.font_error !== want.font_error)
                    begin
                        $display("%0t: font_error expected %0d got %0d",
                                 $time, want.font_error, out_item.font_error);
                        failed = 1'b1;
                    end
                end
                recv_gap = gap_len(recv_burst);
            end
            if ($urandom_range(0, 63) == 0)
                recv_burst = !recv_burst;
            // one long hold-off so the block backs up and stalls its input
            if (!hold_done && results_seen >= 300)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int directed_n;
        int x, y, n, m;
        bit inv, sat_done;
        logic [1:0] fs;
        int r;

        for (int i = 0; i < STORE; i++)
            frame_bytes[i] = 8'h00;
        pen_col  = '0;
        pen_row  = '0;
        col_top  = '0;
        sat_done = 1'b0;

        // buffer is zero after reset
        add_read(0);
        add_read(STORE - 1);
        // 12-row glyph: second byte only paints four rows, then the next column
        add_paint(1, 0, 0, 8'hFF, FONT_12, 1'b0);
        add_paint(0, 0, 0, 8'hA5, FONT_12, 1'b0);
        add_read(0);
        add_read(1);
        // unsupported font leaves the pen alone
        add_paint(1, 50, 30, 8'hFF, FONT_BAD, 1'b0);
        add_paint(0, 0, 0, 8'h81, FONT_16, 1'b0);
        add_read(8);
        // inverted 24-row glyph at an unaligned row
        add_paint(1, 10, 5, 8'h0F, FONT_24, 1'b1);
        add_paint(0, 0, 0, 8'h3C, FONT_24, 1'b1);
        add_paint(0, 0, 0, 8'hF0, FONT_24, 1'b1);
        add_read(80);
        add_read(82);
        // height shrinks mid-character: next column after one more pixel
        add_paint(1, 20, 0, 8'hFF, FONT_24, 1'b0);
        add_paint(0, 0, 0, 8'hFF, FONT_24, 1'b0);
        add_paint(0, 0, 0, 8'hFF, FONT_12, 1'b0);
        add_paint(0, 0, 0, 8'hFF, FONT_12, 1'b0);
        add_read(162);
        add_read(168);
        // bottom-right corner: lower rows and the next column fall off the panel
        add_paint(1, 127, 63, 8'hFF, FONT_16, 1'b0);
        add_paint(0, 0, 0, 8'hFF, FONT_16, 1'b0);
        add_read(STORE - 1);
        // both fills, and the idle request code
        add_clear(1'b1);
        add_read(517);
        add_clear(1'b0);
        glyph_requests.push_back(noise_fields());
        glyph_requests[$].req_type = REQ_NOP;
        directed_n = glyph_requests.size();

        // random part: mostly whole characters followed by reads of their area
        while (glyph_requests.size() < directed_n + RANDOM_N)
        begin
            r = $urandom_range(0, 99);
            if (!sat_done && glyph_requests.size() > directed_n + 400)
            begin
                // run the pen off the right edge until its column saturates
                sat_done = 1'b1;
                add_clear(1'b0);
                add_paint(1, 127, 0, 8'hFF, FONT_16, 1'b0);
                for (int k = 0; k < 2 * 130 + 4; k++)
                    add_paint(0, $urandom_range(0, 127), $urandom_range(0, 63), 8'hFF,
                              FONT_16, 1'b0);
                for (int k = 0; k < 3; k++)
                    add_read(k);
            end
            else if (r < 60)
            begin
                x   = ($urandom_range(0, 4) == 0) ? $urandom_range(118, 127)
                                                   : $urandom_range(0, 127);
                y   = $urandom_range(0, 63);
                fs  = ($urandom_range(0, 19) == 0) ? FONT_BAD : 2'($urandom_range(0, 2));
                inv = 1'($urandom_range(0, 1));
                n   = $urandom_range(1, 12);
                add_paint(1, x, y, 8'($urandom_range(0, 255)), fs, inv);
                for (int k = 1; k < n; k++)
                    add_paint(0, $urandom_range(0, 127), $urandom_range(0, 63),
                              8'($urandom_range(0, 255)),
                              ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : fs,
                              ($urandom_range(0, 9) == 0) ? !inv : inv);
                m = $urandom_range(2, 5);
                for (int k = 0; k < m; k++)
                    add_read(((x + $urandom_range(0, 6)) * DISP_PAGES + (y >> 3)
                              + $urandom_range(0, 3)) % STORE);
            end
            else if (r < 78)
                add_read($urandom_range(0, STORE - 1));
            else if (r < 98)
            begin
                // loose noise: any request code but clear, with random fields
                glyph_requests.push_back(noise_fields());
                if (glyph_requests[$].req_type == REQ_CLEAR)
                    glyph_requests[$].req_type = REQ_READ;
            end
            else
                add_clear(1'($urandom_range(0, 1)));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (glyph_requests.size() > 0 || in_valid || blit_outcomes.size() > 0);
        repeat (20) @(posedge clk);

        if (!failed)
            $display("glyph_column_blitter_core_tb: PASS");
        else
            $display("glyph_column_blitter_core_tb: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("glyph_column_blitter_core_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/gcb_pkg.sv
hdl/gcb_ctrl.sv
hdl/gcb_datapath.sv
hdl/glyph_column_blitter_core.sv
tb/sv/glyph_column_blitter_core_tb.sv
